>>> rtl/assert_macros.svh
// Assertion macros for the convolution filter RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("kc3: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("kc3: next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

>>> rtl/kc3_pkg.sv
// Shared constants, register codes and types for the 3x3 convolution filter.
// No dependencies; every other file of the block but the assertion macro header imports this package.
`timescale 1ns / 1ps

package kc3_pkg;

  // Window geometry and field widths.
  localparam int KERNEL_SIZE     = 3;
  localparam int DEF_SAMPLE_BITS = 8;
  localparam int WEIGHT_BITS     = 8;
  localparam int ROW_BITS        = KERNEL_SIZE * WEIGHT_BITS;
  localparam int SCALE_BITS      = 16;
  localparam int SCALE_FRAC      = 8;
  localparam int OUT_BITS        = 9;
  localparam int OUT_MAX         = 255;

  // Configuration port.
  localparam int CFG_DATA_BITS  = ROW_BITS;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WROW_TOP = 3'd0,
    REG_WROW_MID = 3'd1,
    REG_WROW_BOT = 3'd2,
    REG_SCALE    = 3'd3,
    REG_ABS_EN   = 3'd4
  } kc3_reg_idx_t;

  // Register reset values: identity kernel, unity scale, magnitude on.
  localparam logic [ROW_BITS-1:0]   RST_WROW_TOP = ROW_BITS'(0);
  localparam logic [ROW_BITS-1:0]   RST_WROW_MID = ROW_BITS'(256);
  localparam logic [ROW_BITS-1:0]   RST_WROW_BOT = ROW_BITS'(0);
  localparam logic [SCALE_BITS-1:0] RST_SCALE    = SCALE_BITS'(256);
  localparam logic                  RST_ABS_EN   = 1'b1;

  // Load enables for the stages behind the lanes.
  typedef struct packed {
    logic acc_en;
    logic prod_en;
    logic out_en;
  } kc3_stage_en_t;

endpackage

>>> rtl/kc3_win_if.sv
// Input channel of the convolution filter: one 3x3 window per item.
// Depends on kc3_pkg for the default sample width.
`timescale 1ns / 1ps

interface kc3_win_if import kc3_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pix_r0_c0;
  logic [SAMPLE_BITS-1:0] pix_r0_c1;
  logic [SAMPLE_BITS-1:0] pix_r0_c2;
  logic [SAMPLE_BITS-1:0] pix_r1_c0;
  logic [SAMPLE_BITS-1:0] window_center;
  logic [SAMPLE_BITS-1:0] pix_r1_c2;
  logic [SAMPLE_BITS-1:0] pix_r2_c0;
  logic [SAMPLE_BITS-1:0] pix_r2_c1;
  logic [SAMPLE_BITS-1:0] pix_r2_c2;

  modport source (
    output valid, pix_r0_c0, pix_r0_c1, pix_r0_c2, pix_r1_c0, window_center,
           pix_r1_c2, pix_r2_c0, pix_r2_c1, pix_r2_c2,
    input  ready
  );

  modport sink (
    input  valid, pix_r0_c0, pix_r0_c1, pix_r0_c2, pix_r1_c0, window_center,
           pix_r1_c2, pix_r2_c0, pix_r2_c1, pix_r2_c2,
    output ready
  );
endinterface

>>> rtl/kc3_res_if.sv
// Output channel of the convolution filter: one filtered value per item.
// Depends on kc3_pkg for the result width.
`timescale 1ns / 1ps

interface kc3_res_if import kc3_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] filtered_value;

  modport source (
    output valid, filtered_value,
    input  ready
  );

  modport sink (
    input  valid, filtered_value,
    output ready
  );
endinterface

>>> rtl/kc3_row_lane.sv
// One row lane: three sample-by-weight products summed into a register.
// Depends on kc3_pkg; instantiated once per kernel row by the top level.
`timescale 1ns / 1ps

module kc3_row_lane import kc3_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ROW_BITS-1:0]         row_weights,
  input  logic [SAMPLE_BITS-1:0]      pix [KERNEL_SIZE],
  output logic signed [SAMPLE_BITS+9:0] row_sum
);

  localparam int ROW_W = SAMPLE_BITS + 10;

  logic signed [ROW_W-1:0] prod [KERNEL_SIZE];

  // Each tap: unsigned sample times signed 8-bit weight, exact.
  always_comb begin
    for (int c = 0; c < KERNEL_SIZE; c++) begin
      prod[c] = $signed({1'b0, pix[c]}) *
                $signed(row_weights[c*WEIGHT_BITS +: WEIGHT_BITS]);
    end
  end

  // Row sum register; three products never overflow the lane width.
  always_ff @(posedge clk) begin
    if (en) begin
      row_sum <= prod[0] + prod[1] + prod[2];
    end
  end

endmodule

>>> rtl/kc3_merge.sv
// Merging stages: sum the row lanes, apply the Q8.8 scale, then magnitude,
// optional sign and clamp into the result register. Depends on kc3_pkg.
`timescale 1ns / 1ps

module kc3_merge import kc3_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  kc3_stage_en_t                 stage_en,
  input  logic signed [SAMPLE_BITS+9:0] row_sum [KERNEL_SIZE],
  input  logic [SCALE_BITS-1:0]         scale_q8,
  input  logic                          abs_enable,
  output logic signed [OUT_BITS-1:0]    filtered_value
);

  localparam int ACC_W  = SAMPLE_BITS + 12;
  localparam int PROD_W = ACC_W + SCALE_BITS + 1;
  localparam int SHR_W  = PROD_W - SCALE_FRAC;
  localparam int MAG_W  = OUT_BITS - 1;

  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic                     neg;
  logic [PROD_W-1:0]        mag;
  logic [SHR_W-1:0]         shifted;
  logic [MAG_W-1:0]         mag_sat;
  logic signed [OUT_BITS-1:0] result_next;

  // Full nine-tap sum from the three lanes.
  always_ff @(posedge clk) begin
    if (stage_en.acc_en) begin
      acc <= ACC_W'(row_sum[0]) + ACC_W'(row_sum[1]) + ACC_W'(row_sum[2]);
    end
  end

  // Scale multiply; the scale is unsigned so it gets a zero sign bit.
  always_ff @(posedge clk) begin
    if (stage_en.prod_en) begin
      prod <= acc * $signed({1'b0, scale_q8});
    end
  end

  // Shift the magnitude so the result truncates toward zero, saturate,
  // then restore the sign unless magnitude mode is on.
  always_comb begin
    neg     = prod[PROD_W-1];
    mag     = neg ? PROD_W'(-prod) : PROD_W'(prod);
    shifted = mag[PROD_W-1:SCALE_FRAC];
    if (shifted > SHR_W'(OUT_MAX)) begin
      mag_sat = MAG_W'(OUT_MAX);
    end else begin
      mag_sat = shifted[MAG_W-1:0];
    end
    if (neg && !abs_enable) begin
      result_next = -$signed({1'b0, mag_sat});
    end else begin
      result_next = $signed({1'b0, mag_sat});
    end
  end

  // Output register, the last stage of the pipeline.
  always_ff @(posedge clk) begin
    if (stage_en.out_en) begin
      filtered_value <= result_next;
    end
  end

endmodule

>>> rtl/kernel_convolution_3x3_clamp_unit.sv
// 3x3 convolution filter with Q8.8 scale, optional magnitude and clamp to
// +/-255. Takes one window per clock while results are not stalled and
// returns one result per window; the rate is set by the four register
// stages (row lanes, tap sum, scale multiply, result register), each of
// which holds one item, with one multiplier per tap and one for the scale.
// Each stage moves as soon as the stage behind it has room, so a stalled
// result only blocks input once the pipeline is full. Weights, scale and
// magnitude mode come from the write port and should be changed only while
// no item is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kernel_convolution_3x3_clamp_unit import kc3_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  kc3_win_if.sink                   win,
  kc3_res_if.source                 res
);

  localparam int ROW_W = SAMPLE_BITS + 10;

  logic [ROW_BITS-1:0]   wrow [KERNEL_SIZE];
  logic [SCALE_BITS-1:0] scale_q8;
  logic                  abs_enable;

  logic [SAMPLE_BITS-1:0] pix [KERNEL_SIZE][KERNEL_SIZE];
  logic signed [ROW_W-1:0] row_sum [KERNEL_SIZE];

  logic          lane_valid;
  logic          acc_valid;
  logic          prod_valid;
  logic          out_valid;
  logic          lane_en;
  kc3_stage_en_t stage_en;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      wrow[0]    <= RST_WROW_TOP;
      wrow[1]    <= RST_WROW_MID;
      wrow[2]    <= RST_WROW_BOT;
      scale_q8   <= RST_SCALE;
      abs_enable <= RST_ABS_EN;
    end else if (cfg_wr_en) begin
      unique case (kc3_reg_idx_t'(cfg_index))
        REG_WROW_TOP: wrow[0]    <= cfg_data[ROW_BITS-1:0];
        REG_WROW_MID: wrow[1]    <= cfg_data[ROW_BITS-1:0];
        REG_WROW_BOT: wrow[2]    <= cfg_data[ROW_BITS-1:0];
        REG_SCALE:    scale_q8   <= cfg_data[SCALE_BITS-1:0];
        REG_ABS_EN:   abs_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Window samples arranged by row and column.
  assign pix[0][0] = win.pix_r0_c0;
  assign pix[0][1] = win.pix_r0_c1;
  assign pix[0][2] = win.pix_r0_c2;
  assign pix[1][0] = win.pix_r1_c0;
  assign pix[1][1] = win.window_center;
  assign pix[1][2] = win.pix_r1_c2;
  assign pix[2][0] = win.pix_r2_c0;
  assign pix[2][1] = win.pix_r2_c1;
  assign pix[2][2] = win.pix_r2_c2;

  // A stage loads when it is empty or the stage after it loads too.
  assign stage_en.out_en  = !out_valid || res.ready;
  assign stage_en.prod_en = !prod_valid || stage_en.out_en;
  assign stage_en.acc_en  = !acc_valid || stage_en.prod_en;
  assign lane_en          = !lane_valid || stage_en.acc_en;
  assign win.ready        = lane_en;

  // Valid bits that travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
      acc_valid  <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (lane_en) begin
        lane_valid <= win.valid;
      end
      if (stage_en.acc_en) begin
        acc_valid <= lane_valid;
      end
      if (stage_en.prod_en) begin
        prod_valid <= acc_valid;
      end
      if (stage_en.out_en) begin
        out_valid <= prod_valid;
      end
    end
  end

  // One lane per kernel row.
  for (genvar r = 0; r < KERNEL_SIZE; r++) begin : g_lane
    kc3_row_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk         (clk),
      .en          (lane_en),
      .row_weights (wrow[r]),
      .pix         (pix[r]),
      .row_sum     (row_sum[r])
    );
  end

  kc3_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk            (clk),
    .stage_en       (stage_en),
    .row_sum        (row_sum),
    .scale_q8       (scale_q8),
    .abs_enable     (abs_enable),
    .filtered_value (res.filtered_value)
  );

  assign res.valid = out_valid;

  // An accepted window occupies the lane stage in the next cycle.
  `ASSERT_NEXT(a_accept_fills_lane, clk, rst, win.valid && win.ready, lane_valid)
  // A lane item that cannot move on is still there next cycle.
  `ASSERT_NEXT(a_lane_holds, clk, rst, lane_valid && !stage_en.acc_en, lane_valid)
  // The clamp never lets the one value outside -255..255 through.
  `ASSERT_IMPLIES(a_out_range, clk, rst, res.valid, res.filtered_value != 9'h100)

endmodule
